>>> design/cch_pkg.sv
// package for the counted chained hash table
// shared state codes, actions and command/status structs; no dependencies
package cch_pkg;

    localparam logic [1:0] ACT_SEARCH = 2'd0;
    localparam logic [1:0] ACT_INSERT = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam int KEY_W   = 31;
    localparam int COUNT_W = 16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [4:0] BUCKET_COUNT_RESET = 5'd11;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOD,
        ST_HEAD,
        ST_READ,
        ST_CHECK,
        ST_WRITE,
        ST_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture input beat
        logic mod_step;   // one modulo subtract step
        logic head_read;  // fetch bucket head, start walk
        logic node_read;  // issue node read at current pointer
        logic node_eval;  // evaluate fetched node
        logic commit;     // perform the write-back
        logic finish;     // set result register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic mod_done;
        logic walk_more;  // pointer valid and step budget left
        logic hit_now;    // node ends the walk with a hit
    } stat_t;

endpackage

>>> design/cch_ram.sv
// generic single-port-write, single-read ram with registered read
// no dependencies
module cch_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> design/cch_ctrl.sv
// controller for the counted chained hash table
// depends on cch_pkg
module cch_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  logic           out_stall,
    input  cch_pkg::stat_t stat,
    output cch_pkg::cmd_t  cmd
);
    cch_pkg::state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cch_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign in_stall  = (state_reg != cch_pkg::ST_IDLE);

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            cch_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = cch_pkg::ST_MOD;
                end
            end
            cch_pkg::ST_MOD:
            begin
                if (stat.mod_done)
                begin
                    cmd.head_read = 1'b1;
                    state_next    = cch_pkg::ST_HEAD;
                end
                else
                begin
                    cmd.mod_step = 1'b1;
                end
            end
            cch_pkg::ST_HEAD, cch_pkg::ST_READ:
            begin
                if (stat.walk_more)
                begin
                    cmd.node_read = 1'b1;
                    state_next    = cch_pkg::ST_CHECK;
                end
                else
                begin
                    state_next = cch_pkg::ST_WRITE;
                end
            end
            cch_pkg::ST_CHECK:
            begin
                cmd.node_eval = 1'b1;
                state_next    = stat.hit_now ? cch_pkg::ST_WRITE : cch_pkg::ST_READ;
            end
            cch_pkg::ST_WRITE:
            begin
                cmd.commit = 1'b1;
                state_next = cch_pkg::ST_DONE;
            end
            cch_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = cch_pkg::ST_IDLE;
                end
            end
            default: state_next = cch_pkg::ST_IDLE;
        endcase
    end
endmodule

>>> design/cch_datapath.sv
// datapath: modulo unit, bucket heads, node memories and walk registers
// depends on cch_pkg and cch_ram
module cch_datapath #(
    parameter int MAX_BUCKETS = 16,
    parameter int POOL_NODES  = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [4:0]                  cfg_data,
    input  logic [1:0]                  action,
    input  logic [cch_pkg::KEY_W-1:0]   key,
    input  cch_pkg::cmd_t               cmd,
    output cch_pkg::stat_t              stat,
    output logic                        hit,
    output logic                        status
);
    localparam int AW = $clog2(POOL_NODES);
    localparam int PW = $clog2(POOL_NODES + 1);
    localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int MW = $clog2(MAX_BUCKETS + 1);
    localparam int KW = cch_pkg::KEY_W;
    localparam int CW = cch_pkg::COUNT_W;
    localparam int SW = $clog2(POOL_NODES + 1);
    localparam logic [PW-1:0] NIL = PW'(POOL_NODES);

    logic [4:0]    bcount_reg;
    logic [1:0]    act_reg;
    logic [KW-1:0] key_reg;
    logic [KW-1:0] rem_reg;         // modulo remainder, reduced in steps
    logic [5:0]    sh_reg;          // current shift of the modulus
    logic [MW-1:0] mod_reg;
    logic [PW-1:0] head_reg [MAX_BUCKETS];
    // tail of each bucket: a fresh node's link is never written, so the
    // walk ends at the tail instead
    logic [PW-1:0] tail_reg [MAX_BUCKETS];
    logic [PW-1:0] alloc_reg;
    logic [PW-1:0] ptr_reg, last_reg, free_reg;
    logic [SW-1:0] steps_reg;
    logic          found_reg;
    logic [PW-1:0] fptr_reg;
    logic [CW-1:0] fcount_reg;
    logic          full_reg;        // pool-full outcome of the write-back
    logic          hit_reg, status_reg;

    // effective modulus, clamped to one through max buckets
    logic [MW-1:0] mod_eff;
    always_comb
    begin
        if (bcount_reg == 5'd0)
            mod_eff = MW'(1);
        else if ({27'd0, bcount_reg} > 32'(MAX_BUCKETS))
            mod_eff = MW'(MAX_BUCKETS);
        else
            mod_eff = MW'(bcount_reg);
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bcount_reg <= cch_pkg::BUCKET_COUNT_RESET;
        else if (cfg_we)
            bcount_reg <= cfg_data;
    end

    // restoring modulo: one shifted subtract a cycle, shift from KW-1 down to 0
    logic [KW+MW-1:0] mod_sh;
    assign mod_sh = {{KW{1'b0}}, mod_reg} << sh_reg;
    assign stat.mod_done = (sh_reg == 6'd63);

    logic [BW-1:0] bucket;
    assign bucket = BW'(rem_reg);

    // node memories
    logic          key_we, next_we, cnt_we;
    logic [AW-1:0] key_wa, next_wa, cnt_wa, raddr;
    logic [KW-1:0] key_wd, key_rd;
    logic [PW-1:0] next_wd, next_rd;
    logic [CW-1:0] cnt_wd, cnt_rd;

    assign raddr = AW'(ptr_reg);

    cch_ram #(.WIDTH(KW), .DEPTH(POOL_NODES)) u_key (
        .clk(clk), .we(key_we), .waddr(key_wa), .wdata(key_wd),
        .raddr(raddr), .rdata(key_rd));
    cch_ram #(.WIDTH(PW), .DEPTH(POOL_NODES)) u_next (
        .clk(clk), .we(next_we), .waddr(next_wa), .wdata(next_wd),
        .raddr(raddr), .rdata(next_rd));
    cch_ram #(.WIDTH(CW), .DEPTH(POOL_NODES)) u_cnt (
        .clk(clk), .we(cnt_we), .waddr(cnt_wa), .wdata(cnt_wd),
        .raddr(raddr), .rdata(cnt_rd));

    // walk status
    assign stat.walk_more = (ptr_reg < alloc_reg) && (ptr_reg < NIL)
                            && (steps_reg < SW'(POOL_NODES));
    logic key_eq;
    assign key_eq = (key_rd == key_reg);
    // insert stops on any node with the key, the others only on a live one
    assign stat.hit_now = key_eq
                          && ((act_reg == cch_pkg::ACT_INSERT) || (cnt_rd != '0));

    // write-back decode
    logic do_fresh;
    assign do_fresh = (act_reg == cch_pkg::ACT_INSERT) && !found_reg
                      && (free_reg == NIL) && (alloc_reg < NIL);
    always_comb
    begin
        key_we  = 1'b0;
        next_we = 1'b0;
        cnt_we  = 1'b0;
        key_wa  = AW'(free_reg);
        next_wa = AW'(last_reg);
        cnt_wa  = AW'(fptr_reg);
        key_wd  = key_reg;
        next_wd = alloc_reg;
        cnt_wd  = CW'(1);
        if (cmd.commit)
        begin
            if (found_reg)
            begin
                if (act_reg == cch_pkg::ACT_INSERT)
                begin
                    cnt_we = (fcount_reg != cch_pkg::COUNT_MAX);
                    cnt_wd = fcount_reg + CW'(1);
                end
                else if (act_reg == cch_pkg::ACT_REMOVE)
                begin
                    cnt_we = 1'b1;
                    cnt_wd = fcount_reg - CW'(1);
                end
            end
            else if (act_reg == cch_pkg::ACT_INSERT && free_reg != NIL)
            begin
                key_we = 1'b1;
                cnt_we = 1'b1;
                cnt_wa = AW'(free_reg);
            end
            else if (do_fresh)
            begin
                key_we  = 1'b1;
                key_wa  = AW'(alloc_reg);
                cnt_we  = 1'b1;
                cnt_wa  = AW'(alloc_reg);
                next_we = (last_reg != NIL);
            end
        end
    end

    // control and walk registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg    <= cch_pkg::ACT_SEARCH;
            key_reg    <= '0;
            rem_reg    <= '0;
            mod_reg    <= '0;
            ptr_reg    <= NIL;
            last_reg   <= NIL;
            free_reg   <= NIL;
            steps_reg  <= '0;
            found_reg  <= 1'b0;
            fptr_reg   <= NIL;
            fcount_reg <= '0;
            full_reg   <= 1'b0;
            alloc_reg  <= '0;
            hit_reg    <= 1'b0;
            status_reg <= 1'b0;
            sh_reg     <= 6'd63;
            for (int i = 0; i < MAX_BUCKETS; i++)
            begin
                head_reg[i] <= NIL;
                tail_reg[i] <= NIL;
            end
        end
        else
        begin
            if (cmd.load)
            begin
                act_reg   <= action;
                key_reg   <= key;
                rem_reg   <= key;
                mod_reg   <= mod_eff;
                sh_reg    <= 6'(KW - 1);
                found_reg <= 1'b0;
                free_reg  <= NIL;
                last_reg  <= NIL;
                steps_reg <= '0;
            end
            if (cmd.mod_step)
            begin
                if ({{MW{1'b0}}, rem_reg} >= mod_sh)
                    rem_reg <= KW'({{MW{1'b0}}, rem_reg} - mod_sh);
                sh_reg <= sh_reg - 6'd1;
            end
            if (cmd.head_read)
                ptr_reg <= head_reg[bucket];
            if (cmd.node_read)
                steps_reg <= steps_reg + SW'(1);
            if (cmd.node_eval)
            begin
                if (stat.hit_now)
                begin
                    found_reg  <= 1'b1;
                    fptr_reg   <= ptr_reg;
                    fcount_reg <= cnt_rd;
                end
                else
                begin
                    if (cnt_rd == '0 && free_reg == NIL)
                        free_reg <= ptr_reg;
                    last_reg <= ptr_reg;
                    // the tail keeps a stale link; the walk is cut there
                    ptr_reg  <= (ptr_reg == tail_reg[bucket]) ? NIL : next_rd;
                end
            end
            if (cmd.commit)
            begin
                full_reg <= (act_reg == cch_pkg::ACT_INSERT) && !found_reg
                            && (free_reg == NIL) && (alloc_reg >= NIL);
                if (do_fresh)
                begin
                    alloc_reg <= alloc_reg + PW'(1);
                    if (last_reg == NIL)
                        head_reg[bucket] <= alloc_reg;
                    tail_reg[bucket] <= alloc_reg;
                end
            end
            if (cmd.finish)
            begin
                hit_reg    <= found_reg && (act_reg != cch_pkg::ACT_UNUSED);
                status_reg <= full_reg;
            end
        end
    end

    assign hit    = hit_reg;
    assign status = status_reg;
endmodule

>>> design/counted_chained_hash_table.sv
// top level of the counted chained hash table
// depends on cch_pkg, cch_ctrl, cch_datapath and cch_ram
//
// usage: an input beat (action, key) is taken when in_valid is high and
// in_stall low; exactly one result beat (hit, status) follows on out_valid.
// the block handles one item at a time. after the input beat, the
// bit-serial modulo and the bucket head read come first, then for each
// chain node visited a node memory read, then a compare; a walk that runs
// off the chain takes a closing step, then come write-back and result.
// in_stall drops with the result, so the next beat can be taken while the
// result is shown. while the receiver stalls, the result holds in the
// output register; one more item can be taken and walked, and it then
// waits with in_stall high until the register frees. bucket_count is
// written through cfg_we/cfg_data; the user must write it only while idle,
// the block itself does not enforce this. reset clears all bucket heads to
// empty and the allocation count to zero; node memories need no clearing,
// only allocated nodes are read.
module counted_chained_hash_table #(
    parameter int MAX_BUCKETS = 16,
    parameter int POOL_NODES  = 256
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [4:0]                cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                action,
    input  logic [cch_pkg::KEY_W-1:0] key,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      hit,
    output logic                      status
);
    cch_pkg::cmd_t  cmd;
    cch_pkg::stat_t stat;

    cch_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall), .stat(stat), .cmd(cmd));

    cch_datapath #(.MAX_BUCKETS(MAX_BUCKETS), .POOL_NODES(POOL_NODES)) u_dp (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .action(action), .key(key), .cmd(cmd), .stat(stat),
        .hit(hit), .status(status));

    // a pool-full report never comes with a hit
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(hit && status))
        else $error("hit and status both set");

    // an accepted input beat closes the input while the item is worked on
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input open right after a beat");

    // a stalled result holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(hit) && $stable(status)))
        else $error("stalled result changed");
endmodule

>>> tb/sv/tb_counted_chained_hash_table.sv
// self-checking testbench for counted_chained_hash_table
// depends on cch_pkg and the counted_chained_hash_table rtl
module tb_counted_chained_hash_table;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KW = cch_pkg::KEY_W;
    localparam int MAX_B = 16;
    localparam int POOL = 256;
    localparam int NIL = POOL;
    localparam int N_RANDOM = 1000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [4:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic [1:0] action;
    logic [KW-1:0] key;
    logic out_valid;
    logic out_stall;
    logic hit;
    logic status;

    counted_chained_hash_table dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .action(action), .key(key),
        .out_valid(out_valid), .out_stall(out_stall), .hit(hit), .status(status)
    );

    typedef struct packed {
        logic hit;
        logic status;
    } lookup_res_t;

    // shadow copy of the table
    logic [4:0] sh_buckets;
    int sh_head [MAX_B];
    logic [KW-1:0] sh_key [POOL];
    int sh_next [POOL];
    int sh_count [POOL];
    int sh_alloc;

    lookup_res_t pending_results [$];
    int errors;
    bit rx_hold;
    bit quiet_phase;

    // directed table; check 1 means the expected result is typed in
    typedef struct {
        logic [1:0] act;
        logic [KW-1:0] k;
        bit chk;
        lookup_res_t res;
    } dir_row_t;

    function automatic int bucket_index(logic [KW-1:0] k);
        int m;
        m = sh_buckets;
        if (m == 0) m = 1;
        if (m > MAX_B) m = MAX_B;
        return int'(k % m);
    endfunction

    function automatic bit link_ok(int p);
        return p < sh_alloc && p < POOL;
    endfunction

    function automatic int find_live(int b, logic [KW-1:0] k);
        int p;
        int steps;
        p = sh_head[b];
        steps = 0;
        while (link_ok(p) && steps < POOL)
        begin
            if (sh_key[p] == k && sh_count[p] != 0) return p;
            p = sh_next[p];
            steps++;
        end
        return NIL;
    endfunction

    // apply one beat to the shadow table and return its result
    function automatic lookup_res_t table_update(logic [1:0] act, logic [KW-1:0] k);
        lookup_res_t r;
        int b;
        int p;
        int last;
        int freeslot;
        int steps;
        r = '0;
        b = bucket_index(k);
        if (act == cch_pkg::ACT_SEARCH)
        begin
            r.hit = find_live(b, k) != NIL;
        end
        else if (act == cch_pkg::ACT_REMOVE)
        begin
            p = find_live(b, k);
            if (p != NIL)
            begin
                sh_count[p]--;
                r.hit = 1'b1;
            end
        end
        else if (act == cch_pkg::ACT_INSERT)
        begin
            p = sh_head[b];
            last = NIL;
            freeslot = NIL;
            steps = 0;
            while (link_ok(p) && steps < POOL)
            begin
                if (sh_key[p] == k)
                begin
                    if (sh_count[p] < int'(cch_pkg::COUNT_MAX)) sh_count[p]++;
                    r.hit = 1'b1;
                    return r;
                end
                if (sh_count[p] == 0 && freeslot == NIL) freeslot = p;
                last = p;
                p = sh_next[p];
                steps++;
            end
            if (freeslot != NIL)
            begin
                sh_key[freeslot] = k;
                sh_count[freeslot] = 1;
            end
            else if (sh_alloc >= POOL)
            begin
                r.status = 1'b1;
            end
            else
            begin
                sh_key[sh_alloc] = k;
                sh_count[sh_alloc] = 1;
                sh_next[sh_alloc] = NIL;
                if (last != NIL) sh_next[last] = sh_alloc;
                else sh_head[b] = sh_alloc;
                sh_alloc++;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // timeout
    initial
    begin
        #20ms;
        $display("tb_counted_chained_hash_table failed");
        $finish;
    end

    // result checker
    always @(posedge clk)
    begin
        lookup_res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected beat", 1, 0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (hit !== want.hit) report_mismatch("hit", hit, want.hit);
                if (status !== want.status) report_mismatch("status", status, want.status);
            end
        end
    end

    // receiver stall
    always @(negedge clk)
    begin
        if (rx_hold) out_stall <= 1'b1;
        else if (quiet_phase) out_stall <= 1'b0;
        else out_stall <= ($urandom_range(99) < 12);
    end

    task automatic send_beat(logic [1:0] act, logic [KW-1:0] k, output lookup_res_t r);
        while (!quiet_phase && $urandom_range(99) < 12) @(negedge clk);
        in_valid = 1'b1;
        action = act;
        key = k;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        r = table_update(act, k);
        pending_results.push_back(r);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(negedge clk);
        repeat (600) @(negedge clk);
    endtask

    task automatic write_buckets(logic [4:0] v);
        wait_drained();
        cfg_we = 1'b1;
        cfg_data = v;
        @(negedge clk);
        cfg_we = 1'b0;
        sh_buckets = v;
    endtask

    function automatic logic [KW-1:0] pick_key(int span);
        if ($urandom_range(9) == 0) return KW'($urandom);
        return KW'($urandom_range(span));
    endfunction

    function automatic logic [1:0] pick_action();
        int r;
        r = $urandom_range(99);
        if (r < 50) return cch_pkg::ACT_INSERT;
        if (r < 72) return cch_pkg::ACT_SEARCH;
        if (r < 97) return cch_pkg::ACT_REMOVE;
        return cch_pkg::ACT_UNUSED;
    endfunction

    initial
    begin
        dir_row_t rows [$];
        lookup_res_t r;
        logic [KW-1:0] kmax;
        int i;
        errors = 0;
        rx_hold = 0;
        quiet_phase = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        action = cch_pkg::ACT_SEARCH;
        key = '0;
        out_stall = 1'b0;
        sh_buckets = cch_pkg::BUCKET_COUNT_RESET;
        foreach (sh_head[j]) sh_head[j] = NIL;
        foreach (sh_count[j])
        begin
            sh_count[j] = 0;
            sh_next[j] = 0;
            sh_key[j] = '0;
        end
        sh_alloc = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part at reset modulus
        kmax = '1;
        rows.push_back('{cch_pkg::ACT_SEARCH, 31'd0, 1, '{1'b0, 1'b0}});
        rows.push_back('{cch_pkg::ACT_REMOVE, kmax, 1, '{1'b0, 1'b0}});
        rows.push_back('{cch_pkg::ACT_INSERT, kmax, 1, '{1'b0, 1'b0}});
        rows.push_back('{cch_pkg::ACT_INSERT, kmax, 1, '{1'b1, 1'b0}});
        rows.push_back('{cch_pkg::ACT_SEARCH, kmax, 1, '{1'b1, 1'b0}});
        rows.push_back('{cch_pkg::ACT_INSERT, 31'd0, 1, '{1'b0, 1'b0}});
        rows.push_back('{cch_pkg::ACT_INSERT, 31'd11, 0, '{1'b0, 1'b0}});
        rows.push_back('{cch_pkg::ACT_INSERT, 31'd22, 0, '{1'b0, 1'b0}});
        rows.push_back('{cch_pkg::ACT_REMOVE, 31'd11, 0, '{1'b0, 1'b0}});
        rows.push_back('{cch_pkg::ACT_SEARCH, 31'd11, 0, '{1'b0, 1'b0}});
        rows.push_back('{cch_pkg::ACT_INSERT, 31'd33, 0, '{1'b0, 1'b0}});
        rows.push_back('{cch_pkg::ACT_INSERT, 31'd11, 0, '{1'b0, 1'b0}});
        rows.push_back('{cch_pkg::ACT_UNUSED, 31'd0, 1, '{1'b0, 1'b0}});
        rows.push_back('{cch_pkg::ACT_REMOVE, 31'd0, 1, '{1'b1, 1'b0}});
        rows.push_back('{cch_pkg::ACT_REMOVE, 31'd0, 1, '{1'b0, 1'b0}});
        rows.push_back('{cch_pkg::ACT_INSERT, 31'd0, 1, '{1'b1, 1'b0}});
        rows.push_back('{cch_pkg::ACT_SEARCH, 31'h2AAAAAAA, 1, '{1'b0, 1'b0}});
        rows.push_back('{cch_pkg::ACT_SEARCH, 31'h55555555, 1, '{1'b0, 1'b0}});
        foreach (rows[j])
        begin
            send_beat(rows[j].act, rows[j].k, r);
            if (rows[j].chk && r !== rows[j].res)
                report_mismatch("directed row", j, 0);
        end

        // modulus extremes, including zero and above the bucket limit
        write_buckets(5'd1);
        for (i = 0; i < 6; i++) send_beat(pick_action(), KW'($urandom_range(4)), r);
        write_buckets(5'd0);
        for (i = 0; i < 4; i++) send_beat(pick_action(), KW'($urandom_range(4)), r);
        write_buckets(5'd31);
        for (i = 0; i < 6; i++) send_beat(pick_action(), KW'($urandom_range(40)), r);
        write_buckets(5'd16);

        // long receiver hold while the sender keeps offering
        fork
            begin
                rx_hold = 1;
                repeat (400) @(negedge clk);
                rx_hold = 0;
            end
            for (i = 0; i < 5; i++)
                send_beat(cch_pkg::ACT_INSERT, KW'($urandom_range(50)), r);
        join

        // sender pause until every result is back
        wait_drained();

        // random phases across settings; later phases fill the pool
        for (int ph = 0; ph < 8; ph++)
        begin
            logic [4:0] nb;
            nb = (ph == 7) ? 5'd16 : 5'($urandom_range(1, 16));
            write_buckets(nb);
            quiet_phase = (ph == 3);
            for (i = 0; i < N_RANDOM / 8; i++)
                send_beat(pick_action(), pick_key(ph < 5 ? 60 : 400), r);
        end
        quiet_phase = 0;
        // push past a full pool
        for (i = 0; i < 60; i++)
            send_beat(cch_pkg::ACT_INSERT, KW'($urandom_range(1000, 5000)), r);

        wait_drained();
        if (errors == 0)
            $display("tb_counted_chained_hash_table passed");
        else
            $display("tb_counted_chained_hash_table failed");
        $finish;
    end
endmodule
